FILE: sv/checkerboard_site_reorder_index_macros.svh
// ----------------------------------------------------------------------------
// checkerboard site reorder index: assertion macros
// shared concurrent assertion forms for the reorder index block
// ----------------------------------------------------------------------------
`ifndef CHECKERBOARD_SITE_REORDER_INDEX_MACROS_SVH
`define CHECKERBOARD_SITE_REORDER_INDEX_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CSRI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define CSRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/csri_pkg.sv
// ----------------------------------------------------------------------------
// csri_pkg
// types and constants shared by the checkerboard site reorder index block
// ----------------------------------------------------------------------------
package csri_pkg;

  localparam int MAX_EXTENT     = 64;
  localparam int MATRIX_ENTRIES = 9;
  localparam int NUM_DIRS       = 4;

  localparam int EXT_W   = $clog2(MAX_EXTENT) + 1;
  localparam int PAIR_W  = 23;
  localparam int DIR_W   = 2;
  localparam int COMP_W  = 4;
  localparam int NAT_W   = 30;
  localparam int CHK_W   = 28;
  localparam int SITE_W  = PAIR_W + 1;
  localparam int VOL_W   = 4 * $clog2(MAX_EXTENT) + 1;
  localparam int DC_W    = $clog2((NUM_DIRS - 1) * MATRIX_ENTRIES + (1 << COMP_W));

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENT_T = 3'd3;
  localparam logic [EXT_W-1:0] EXT_RESET = 7'd4;

  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (PAIR_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int DIV_BITS       = DIV_STAGES * BITS_PER_STAGE;
  // queue write, remainder stages, multiply stage, output register
  localparam int LATENCY        = DIV_STAGES + 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PAIR_W-1:0] pair_index;
    logic [DIR_W-1:0]  direction;
    logic [COMP_W-1:0] component;
  } in_item_t;

  typedef struct packed {
    logic [NAT_W-1:0] natural_even_index;
    logic [NAT_W-1:0] natural_odd_index;
    logic [CHK_W-1:0] checker_even_index;
    logic [CHK_W-1:0] checker_odd_index;
    logic             x_offset_even;
  } out_item_t;

  typedef struct packed {
    logic [EXT_W-1:0] ext_x;
    logic [EXT_W-1:0] ext_y;
    logic [EXT_W-1:0] ext_z;
    logic [EXT_W-1:0] ext_t;
  } cfg_t;

  // classified item as held in the queue
  typedef struct packed {
    logic [PAIR_W-1:0] pair_index;
    logic [DC_W-1:0]   dc;
    logic [COMP_W-1:0] component;
  } work_t;

  // item in flight through the remainder cascade
  typedef struct packed {
    logic [PAIR_W-1:0] pair_index;
    logic [DC_W-1:0]   dc;
    logic [COMP_W-1:0] component;
    logic [EXT_W-1:0]  r1;
    logic [EXT_W-1:0]  r2;
    logic [EXT_W-1:0]  r3;
    logic [EXT_W-1:0]  r4;
  } div_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: sv/csri_front.sv
// ----------------------------------------------------------------------------
// csri_front
// accepts items and classifies them into direction/component slot offsets
// ----------------------------------------------------------------------------
module csri_front (
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  csri_pkg::in_item_t   item,
  input  csri_pkg::q_status_t  q_status,
  output logic                 push,
  output csri_pkg::work_t      work
);

  logic [csri_pkg::DC_W-1:0] dc;

  assign busy = rst || q_status.full;
  assign push = start && !busy;

  // slot of the (direction, component) block in natural order
  assign dc = csri_pkg::DC_W'(item.direction) * csri_pkg::DC_W'(csri_pkg::MATRIX_ENTRIES)
            + csri_pkg::DC_W'(item.component);

  assign work.pair_index = item.pair_index;
  assign work.dc         = dc;
  assign work.component  = item.component;

endmodule

FILE: sv/csri_queue.sv
// ----------------------------------------------------------------------------
// csri_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module csri_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  csri_pkg::work_t      wdata,
  input  logic                 pop,
  output csri_pkg::work_t      rdata,
  output csri_pkg::q_status_t  status
);

  csri_pkg::work_t               mem [csri_pkg::QUEUE_DEPTH];
  logic [csri_pkg::QPTR_W-1:0]   wr_ptr;
  logic [csri_pkg::QPTR_W-1:0]   rd_ptr;
  logic [csri_pkg::QCNT_W-1:0]   count;

  function automatic logic [csri_pkg::QPTR_W-1:0] ptr_inc(
    input logic [csri_pkg::QPTR_W-1:0] p
  );
    if (p == csri_pkg::QPTR_W'(csri_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata        = mem[rd_ptr];
  assign status.full  = (count == csri_pkg::QCNT_W'(csri_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: sv/csri_back.sv
// ----------------------------------------------------------------------------
// csri_back
// remainder cascade for the site parity and final index arithmetic
// ----------------------------------------------------------------------------
module csri_back (
  input  logic                 clk,
  input  logic                 rst,
  input  csri_pkg::cfg_t       cfg,
  input  csri_pkg::q_status_t  q_status,
  input  csri_pkg::work_t      work,
  output logic                 pop,
  output logic                 strobe,
  output csri_pkg::out_item_t  result
);

  localparam int EW  = csri_pkg::EXT_W;
  localparam int BPS = csri_pkg::BITS_PER_STAGE;

  csri_pkg::div_t                    stg [csri_pkg::DIV_STAGES];
  logic [csri_pkg::DIV_STAGES-1:0]   vld;
  logic [EW-1:0]                     hx;
  logic [2*EW-1:0]                   vol_xy;
  logic [2*EW-1:0]                   vol_zt;
  logic [4*EW-1:0]                   vol_full;
  logic [csri_pkg::VOL_W-1:0]        vol;
  csri_pkg::div_t                    last;
  logic [csri_pkg::NAT_W-1:0]        prod_c;
  logic [csri_pkg::NAT_W-1:0]        m_prod;
  logic [csri_pkg::SITE_W-1:0]       m_site;
  logic                              m_b;
  logic [csri_pkg::CHK_W-1:0]        m_chk_even;
  logic [csri_pkg::CHK_W-1:0]        m_half_sum;
  logic [csri_pkg::COMP_W-1:0]       m_component;
  logic                              m_valid;

  // one restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [EW:0] div_step(
    input logic [EW-1:0] r,
    input logic          b,
    input logic [EW-1:0] dv
  );
    logic [EW-1:0] sh;
    sh = {r[EW-2:0], b};
    if (sh >= dv) begin
      return {1'b1, sh - dv};
    end
    return {1'b0, sh};
  endfunction

  // quotient bits of each divider feed the next one in the same step
  function automatic csri_pkg::div_t stage_step(
    input csri_pkg::div_t   s,
    input logic [BPS-1:0]   bits,
    input logic [EW-1:0]    dx,
    input logic [EW-1:0]    dy,
    input logic [EW-1:0]    dz,
    input logic [EW-1:0]    dt
  );
    csri_pkg::div_t o;
    logic [EW:0]    t;
    o = s;
    for (int i = BPS - 1; i >= 0; i--) begin
      t    = div_step(o.r1, bits[i], dx);
      o.r1 = t[EW-1:0];
      t    = div_step(o.r2, t[EW], dy);
      o.r2 = t[EW-1:0];
      t    = div_step(o.r3, t[EW], dz);
      o.r3 = t[EW-1:0];
      t    = div_step(o.r4, t[EW], dt);
      o.r4 = t[EW-1:0];
    end
    return o;
  endfunction

  assign pop = !q_status.empty;
  assign hx  = {1'b0, cfg.ext_x[EW-1:1]};

  // volume tracks the extents; the user must keep them steady while items are in flight, the block does not enforce it
  assign vol_full = (4*EW)'(vol_xy) * (4*EW)'(vol_zt);
  always_ff @(posedge clk) begin
    vol_xy <= (2*EW)'(cfg.ext_x) * (2*EW)'(cfg.ext_y);
    vol_zt <= (2*EW)'(cfg.ext_z) * (2*EW)'(cfg.ext_t);
    vol    <= vol_full[csri_pkg::VOL_W-1:0];
  end

  for (genvar k = 0; k < csri_pkg::DIV_STAGES; k++) begin : g_div
    csri_pkg::div_t                 s_in;
    csri_pkg::div_t                 s_out;
    logic [csri_pkg::DIV_BITS-1:0]  dvd;
    if (k == 0) begin : g_first
      assign s_in = '{pair_index: work.pair_index, dc: work.dc,
                      component: work.component,
                      r1: '0, r2: '0, r3: '0, r4: '0};
    end else begin : g_rest
      assign s_in = stg[k-1];
    end
    assign dvd   = csri_pkg::DIV_BITS'(s_in.pair_index);
    assign s_out = stage_step(s_in, dvd[csri_pkg::DIV_BITS-1-k*BPS -: BPS],
                              hx, cfg.ext_y, cfg.ext_z, cfg.ext_t);
    always_ff @(posedge clk) begin
      stg[k] <= s_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      m_valid <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      vld     <= {vld[csri_pkg::DIV_STAGES-2:0], pop};
      m_valid <= vld[csri_pkg::DIV_STAGES-1];
      strobe  <= m_valid;
    end
  end

  assign last   = stg[csri_pkg::DIV_STAGES-1];
  assign prod_c = csri_pkg::NAT_W'(last.dc) * csri_pkg::NAT_W'(vol);

  always_ff @(posedge clk) begin
    m_prod      <= prod_c;
    m_site      <= {last.pair_index, 1'b0};
    // remainders r2..r4 are the y, z and t coordinates
    m_b         <= last.r2[0] ^ last.r3[0] ^ last.r4[0];
    m_chk_even  <= csri_pkg::CHK_W'(last.pair_index)
                 * csri_pkg::CHK_W'(csri_pkg::MATRIX_ENTRIES)
                 + csri_pkg::CHK_W'(last.component);
    m_half_sum  <= csri_pkg::CHK_W'(last.pair_index)
                 + csri_pkg::CHK_W'(vol[csri_pkg::VOL_W-1:1]);
    m_component <= last.component;
  end

  always_ff @(posedge clk) begin
    result.natural_even_index <= m_prod + csri_pkg::NAT_W'(m_site)
                               + csri_pkg::NAT_W'(m_b);
    result.natural_odd_index  <= m_prod + csri_pkg::NAT_W'(m_site)
                               + csri_pkg::NAT_W'(!m_b);
    result.checker_even_index <= m_chk_even;
    result.checker_odd_index  <= m_half_sum * csri_pkg::CHK_W'(csri_pkg::MATRIX_ENTRIES)
                               + csri_pkg::CHK_W'(m_component);
    result.x_offset_even      <= m_b;
  end

endmodule

FILE: sv/checkerboard_site_reorder_index.sv
// ----------------------------------------------------------------------------
// checkerboard_site_reorder_index
// address pairs for natural <-> even/odd lattice site reordering
// ----------------------------------------------------------------------------
// usage:
//   item channel: drive start with an item (pair index, direction, component);
//   the item is taken at a clock edge where start is high and busy is low.
//   result channel: each result sits on result for one cycle with strobe high;
//   the receiver cannot hold it off, so results are never delayed.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes the
//   extents x, y, z, t (indexes 0..3); other indexes are ignored. write only
//   while no item is in flight.
//   throughput: one item per cycle while busy is low. path: an item passes
//   through the queue, 12 remainder stages (two dividend bits each, through
//   a four-deep divider cascade), one multiply stage and the output register.
//   reset: clears the pipeline and queue and sets every extent to 4; busy is
//   high during reset and otherwise only if the queue fills.
// ----------------------------------------------------------------------------
`include "checkerboard_site_reorder_index_macros.svh"

module checkerboard_site_reorder_index (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  csri_pkg::in_item_t                    item,
  output logic                                  strobe,
  output csri_pkg::out_item_t                   result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csri_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [csri_pkg::EXT_W-1:0]            cfg_data
);

  localparam int EW = csri_pkg::EXT_W;

  csri_pkg::cfg_t       cfg;
  csri_pkg::q_status_t  q_status;
  csri_pkg::work_t      f_work;
  csri_pkg::work_t      q_work;
  logic                 push;
  logic                 pop;

  function automatic logic [EW-1:0] clamp_ext(input logic [EW-1:0] v);
    if (v == '0) begin
      return EW'(1);
    end
    if (v > EW'(csri_pkg::MAX_EXTENT)) begin
      return EW'(csri_pkg::MAX_EXTENT);
    end
    return v;
  endfunction

  // x extent in use is even and at least two
  function automatic logic [EW-1:0] clamp_ext_x(input logic [EW-1:0] v);
    logic [EW-1:0] c;
    c = clamp_ext(v) & ~EW'(1);
    if (c < EW'(2)) begin
      c = EW'(2);
    end
    return c;
  endfunction

  assign cfg_ready = 1'b1;

  // extents are stored already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext_x <= csri_pkg::EXT_RESET;
      cfg.ext_y <= csri_pkg::EXT_RESET;
      cfg.ext_z <= csri_pkg::EXT_RESET;
      cfg.ext_t <= csri_pkg::EXT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csri_pkg::REG_EXTENT_X: cfg.ext_x <= clamp_ext_x(cfg_data);
        csri_pkg::REG_EXTENT_Y: cfg.ext_y <= clamp_ext(cfg_data);
        csri_pkg::REG_EXTENT_Z: cfg.ext_z <= clamp_ext(cfg_data);
        csri_pkg::REG_EXTENT_T: cfg.ext_t <= clamp_ext(cfg_data);
        default: ;
      endcase
    end
  end

  csri_front u_front (
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .q_status (q_status),
    .push     (push),
    .work     (f_work)
  );

  csri_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (f_work),
    .pop    (pop),
    .rdata  (q_work),
    .status (q_status)
  );

  csri_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .work     (q_work),
    .pop      (pop),
    .strobe   (strobe),
    .result   (result)
  );

  // every result traces back to an item accepted earlier
  `CSRI_ASSERT_IMPL(a_result_latency, clk, rst, strobe, $past(push, csri_pkg::LATENCY), "result without matching item")
  // the back drains the queue in the cycle after each accept
  `CSRI_ASSERT_NEXT(a_pop_after_push, clk, rst, push, pop, "queued item not taken by back")
  // even and odd sites are neighbours in natural order
  `CSRI_ASSERT_IMPL(a_site_adjacent, clk, rst, strobe, (result.x_offset_even ? (result.natural_even_index == result.natural_odd_index + 1'b1) : (result.natural_odd_index == result.natural_even_index + 1'b1)), "even and odd natural indices not adjacent")

endmodule

FILE: sim/checkerboard_site_reorder_index_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checkerboard_site_reorder_index_tb
// drives pair/direction/component items through the reorder index block under
// several lattice extent settings and checks every address set against an
// in-bench predictor of the even/odd site mapping or a typed-in expectation
// ----------------------------------------------------------------------------
module checkerboard_site_reorder_index_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 165;
  localparam logic [csri_pkg::CFG_INDEX_W-1:0] REG_UNUSED_LO =
    csri_pkg::REG_EXTENT_T + 3'd1;

  typedef struct {
    csri_pkg::in_item_t  stim;
    bit                  typed;
    csri_pkg::out_item_t want;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  csri_pkg::in_item_t               item = '0;
  logic                             strobe;
  csri_pkg::out_item_t              result;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [csri_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [csri_pkg::EXT_W-1:0]       cfg_data = '0;

  // typed-in expectation travels with the item it belongs to
  logic                             typed_valid = 1'b0;
  csri_pkg::out_item_t              typed_addr = '0;

  // bench copy of the extent registers
  logic [csri_pkg::EXT_W-1:0]       ext_x = csri_pkg::EXT_RESET;
  logic [csri_pkg::EXT_W-1:0]       ext_y = csri_pkg::EXT_RESET;
  logic [csri_pkg::EXT_W-1:0]       ext_z = csri_pkg::EXT_RESET;
  logic [csri_pkg::EXT_W-1:0]       ext_t = csri_pkg::EXT_RESET;

  csri_pkg::out_item_t              expected_addr_q[$];
  csri_pkg::out_item_t              expected_head;
  stim_row_t                        directed_rows[$];
  int                               mismatch_count = 0;
  int                               cycle_count = 0;
  bit                               gapless = 1'b0;

  checkerboard_site_reorder_index DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned clamped(logic [csri_pkg::EXT_W-1:0] v);
    if (v == 0) return 1;
    if (v > csri_pkg::MAX_EXTENT) return csri_pkg::MAX_EXTENT;
    return v;
  endfunction

  // x extent is forced even and at least two
  function automatic longint unsigned x_span();
    longint unsigned v;
    v = clamped(ext_x) & ~64'd1;
    if (v < 2) v = 2;
    return v;
  endfunction

  function automatic longint unsigned lattice_volume();
    return x_span() * clamped(ext_y) * clamped(ext_z) * clamped(ext_t);
  endfunction

  function automatic csri_pkg::out_item_t predict_addresses(csri_pkg::in_item_t it);
    longint unsigned lx, ly, lz, lt, vol, half, p, d, c, site, rest, sum, base;
    logic par;
    csri_pkg::out_item_t r;
    lx = x_span();
    ly = clamped(ext_y);
    lz = clamped(ext_z);
    lt = clamped(ext_t);
    vol = lattice_volume();
    half = vol / 2;
    p = it.pair_index;
    d = it.direction;
    c = it.component;
    site = 2 * p;
    // parity of y + z + t of the even-slot site
    rest = site / lx;
    sum = rest % ly;
    rest = rest / ly;
    sum = sum + rest % lz;
    rest = rest / lz;
    sum = sum + rest % lt;
    par = sum[0];
    base = (d * csri_pkg::MATRIX_ENTRIES + c) * vol + site;
    r.natural_even_index = csri_pkg::NAT_W'(base + par);
    r.natural_odd_index  = csri_pkg::NAT_W'(base + (par ^ 1'b1));
    r.checker_even_index = csri_pkg::CHK_W'(p * csri_pkg::MATRIX_ENTRIES + c);
    r.checker_odd_index  = csri_pkg::CHK_W'((p + half) * csri_pkg::MATRIX_ENTRIES + c);
    r.x_offset_even      = par;
    return r;
  endfunction

  function automatic stim_row_t make_row(int unsigned p, int unsigned d, int unsigned c,
                                         bit typed, csri_pkg::out_item_t want);
    stim_row_t row;
    row.stim.pair_index = csri_pkg::PAIR_W'(p);
    row.stim.direction  = csri_pkg::DIR_W'(d);
    row.stim.component  = csri_pkg::COMP_W'(c);
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic csri_pkg::in_item_t random_item();
    csri_pkg::in_item_t it;
    longint unsigned half;
    half = lattice_volume() / 2;
    case ($urandom_range(0, 5))
      0: it.pair_index = csri_pkg::PAIR_W'($urandom);
      1: it.pair_index = csri_pkg::PAIR_W'($urandom_range(0, 63));
      2, 3, 4: it.pair_index = csri_pkg::PAIR_W'($urandom_range(0, 32'(half - 1)));
      default: it.pair_index = csri_pkg::PAIR_W'(half - 1 + $urandom_range(0, 2));
    endcase
    it.direction = csri_pkg::DIR_W'($urandom);
    if ($urandom_range(0, 4) == 0) it.component = csri_pkg::COMP_W'($urandom);
    else it.component = csri_pkg::COMP_W'($urandom_range(0, csri_pkg::MATRIX_ENTRIES - 1));
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_item(csri_pkg::in_item_t it, bit typed, csri_pkg::out_item_t want);
    int gap;
    gap = gapless ? 0 : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 16));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    item        <= it;
    typed_valid <= typed;
    typed_addr  <= want;
    do @(posedge clk); while (busy);
  endtask

  // hold the sender until every outstanding address set has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_addr_q.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [csri_pkg::CFG_INDEX_W-1:0] idx,
                           logic [csri_pkg::EXT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      csri_pkg::REG_EXTENT_X: ext_x = val;
      csri_pkg::REG_EXTENT_Y: ext_y = val;
      csri_pkg::REG_EXTENT_Z: ext_z = val;
      csri_pkg::REG_EXTENT_T: ext_t = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [csri_pkg::EXT_W-1:0] x, logic [csri_pkg::EXT_W-1:0] y,
                           logic [csri_pkg::EXT_W-1:0] z, logic [csri_pkg::EXT_W-1:0] t,
                           int n);
    logic [csri_pkg::CFG_INDEX_W-1:0] order[4];
    logic [csri_pkg::EXT_W-1:0]       vals[4];
    logic [csri_pkg::CFG_INDEX_W-1:0] tmp;
    int                               j;
    int                               k;
    settle();
    order = '{csri_pkg::REG_EXTENT_X, csri_pkg::REG_EXTENT_Y,
              csri_pkg::REG_EXTENT_Z, csri_pkg::REG_EXTENT_T};
    vals  = '{x, y, z, t};
    for (j = 3; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < 4; j++) write_reg(order[j], vals[order[j]]);
    // a write past the last register must leave the extents alone
    write_reg(REG_UNUSED_LO + csri_pkg::CFG_INDEX_W'($urandom_range(0, 3)),
              csri_pkg::EXT_W'($urandom_range(0, 127)));
    cfg_valid <= 1'b0;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) gapless = ($urandom_range(0, 3) == 0);
      send_item(random_item(), 1'b0, '0);
    end
    gapless = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst) begin
      if (start && !busy)
        expected_addr_q = {expected_addr_q,
                           (typed_valid ? typed_addr : predict_addresses(item))};
      if (strobe) begin
        if (expected_addr_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: %h", result));
        end else begin
          expected_head = expected_addr_q.pop_front();
          if (result.natural_even_index !== expected_head.natural_even_index)
            report_mismatch($sformatf("natural_even_index %0d, expected %0d",
              result.natural_even_index, expected_head.natural_even_index));
          if (result.natural_odd_index !== expected_head.natural_odd_index)
            report_mismatch($sformatf("natural_odd_index %0d, expected %0d",
              result.natural_odd_index, expected_head.natural_odd_index));
          if (result.checker_even_index !== expected_head.checker_even_index)
            report_mismatch($sformatf("checker_even_index %0d, expected %0d",
              result.checker_even_index, expected_head.checker_even_index));
          if (result.checker_odd_index !== expected_head.checker_odd_index)
            report_mismatch($sformatf("checker_odd_index %0d, expected %0d",
              result.checker_odd_index, expected_head.checker_odd_index));
          if (result.x_offset_even !== expected_head.x_offset_even)
            report_mismatch($sformatf("x_offset_even %0b, expected %0b",
              result.x_offset_even, expected_head.x_offset_even));
        end
      end
    end
  end

  initial begin
    int k;
    // extents at their reset value of four: volume 256, half volume 128
    directed_rows = {directed_rows, make_row(0, 0, 0, 1'b1,
      '{30'd0, 30'd1, 28'd0, 28'd1152, 1'b0})};
    directed_rows = {directed_rows, make_row(2, 0, 0, 1'b1,
      '{30'd5, 30'd4, 28'd18, 28'd1170, 1'b1})};
    directed_rows = {directed_rows, make_row(0, 3, 8, 1'b1,
      '{30'd8960, 30'd8961, 28'd8, 28'd1160, 1'b0})};
    directed_rows = {directed_rows, make_row(23'h7FFFFF, 3, 15, 1'b1,
      '{30'd16787967, 30'd16787966, 28'd75497478, 28'd75498630, 1'b1})};
    directed_rows = {directed_rows, make_row(1, 0, 1, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(3, 1, 2, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(8, 1, 3, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(32, 2, 4, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(64, 3, 3, 1'b0, '0)};
    // last pair inside the half volume, then beyond it
    directed_rows = {directed_rows, make_row(127, 2, 5, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(128, 3, 6, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(129, 0, 7, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(255, 1, 8, 1'b0, '0)};
    // components past the 3x3 matrix
    directed_rows = {directed_rows, make_row(0, 1, 9, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(5, 2, 15, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(23'h555555, 1, 10, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(23'h2AAAAA, 2, 5, 1'b0, '0)};
    directed_rows = {directed_rows, make_row(23'h400000, 0, 0, 1'b0, '0)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    run_phase(7'd2, 7'd1, 7'd1, 7'd1, PHASE_ITEMS);
    run_phase(7'd64, 7'd64, 7'd64, 7'd64, PHASE_ITEMS);
    // zero extents clamp up, oversize ones clamp down
    run_phase(7'd0, 7'd0, 7'd0, 7'd0, PHASE_ITEMS);
    run_phase(7'd127, 7'd127, 7'd127, 7'd127, PHASE_ITEMS);
    // odd x gets its low bit dropped, too small x is raised to two
    run_phase(7'd7, 7'd3, 7'd5, 7'd9, PHASE_ITEMS);
    run_phase(7'd1, 7'd64, 7'd1, 7'd64, PHASE_ITEMS);
    run_phase(7'd65, 7'd2, 7'd3, 7'd4, PHASE_ITEMS);
    for (k = 0; k < 2; k++)
      run_phase(csri_pkg::EXT_W'($urandom_range(0, 127)),
                csri_pkg::EXT_W'($urandom_range(0, 127)),
                csri_pkg::EXT_W'($urandom_range(0, 127)),
                csri_pkg::EXT_W'($urandom_range(0, 127)),
                PHASE_ITEMS);
    run_phase(csri_pkg::EXT_RESET, csri_pkg::EXT_RESET, csri_pkg::EXT_RESET,
              csri_pkg::EXT_RESET, PHASE_ITEMS);

    settle();
    repeat (csri_pkg::LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
